// File: rtl/cbs_pkg.sv
// Shared widths, register indexes and blend program for the Bezier stepper.
package cbs_pkg;

  localparam int PIX_W      = 11;
  localparam int COORD_W    = 15;
  localparam int STEP_W     = 10;
  localparam int T_W        = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_REGS   = 8;
  localparam int STEPS_DEF  = 50;
  localparam int PROG_LEN   = 8;
  localparam int PROG_W     = 3;
  localparam int QUEUE_LEN  = 4;
  localparam int FRAC_SHIFT = 4;

  localparam logic [REG_IDX_W-1:0] REG_START_X       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_CTRL_X  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_CTRL_Y  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_CTRL_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_CTRL_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_END_X         = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_END_Y         = 3'd7;

  typedef enum logic [1:0] {
    OP_BL3,
    OP_BL2,
    OP_DROP,
    OP_BL0
  } op_t;

  function automatic op_t prog_op(logic [PROG_W-1:0] idx);
    op_t op;
    case (idx)
      3'd0, 3'd1, 3'd2: op = OP_BL3;
      3'd3, 3'd6:       op = OP_DROP;
      3'd4, 3'd5:       op = OP_BL2;
      3'd7:             op = OP_BL0;
      default:          op = OP_DROP;
    endcase
    return op;
  endfunction

endpackage

// File: rtl/cbs_if.sv
// Valid/ready channels for the stepper's tick input and point output.
interface cbs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface cbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [cbs_pkg::COORD_W-1:0] pos_x;
  logic [cbs_pkg::COORD_W-1:0] pos_y;
  logic [cbs_pkg::STEP_W-1:0]  step_index;
  logic                        done_res;

  modport source (output valid, output pos_x, output pos_y, output step_index,
                  output done_res, input ready);
  modport sink (input valid, input pos_x, input pos_y, input step_index,
                input done_res, output ready);
endinterface

// File: rtl/cubic_bezier_stepper.sv
// Cubic Bezier stepper: one curve point per tick by de Casteljau blending.
// Each accepted tick beat yields one output beat with the Q11.4 curve point at
// t = step/STEPS, the step used and a wrap flag. One 17x17 signed multiplier
// does all twelve blends, alternating between the x and y axes so that at most
// one blend issues per cycle; a four-entry shift queue per axis holds the partial
// points. The input is ready again only after the load state, the program
// states (six blends and two queue drops per axis), a drain state for the last
// product and a done state that registers the result once the output is free.
// A finished result may wait in the output register while the next tick is
// taken. Control point registers are written on cfg_we; indexes past the last
// register are ignored.
module cubic_bezier_stepper #(
  parameter int STEPS = cbs_pkg::STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbs_pkg::PIX_W-1:0]     cfg_wdata,
  cbs_in_if.sink                        in_ch,
  cbs_out_if.source                     out_ch
);

  localparam int STEP_INC = 65536 / STEPS;
  localparam logic [cbs_pkg::T_W-1:0] STEP_INC_V = cbs_pkg::T_W'(STEP_INC);
  localparam logic [cbs_pkg::STEP_W:0] STEPS_V = (cbs_pkg::STEP_W + 1)'(STEPS);
  localparam int MUL_W = 2 * (cbs_pkg::COORD_W + 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef logic [cbs_pkg::COORD_W-1:0] coord_t;

  state_t                          state_r;
  logic [cbs_pkg::PIX_W-1:0]       regs_r [cbs_pkg::NUM_REGS];
  logic [cbs_pkg::STEP_W-1:0]      step_r;
  logic [cbs_pkg::STEP_W-1:0]      used_r;
  logic                            done_r;
  logic [cbs_pkg::T_W-1:0]         t_r;
  coord_t                          q_r [2][cbs_pkg::QUEUE_LEN];
  logic [cbs_pkg::PROG_W-1:0]      s_r;
  logic                            axis_r;
  logic                            pend_v_r;
  logic                            pend_axis_r;
  cbs_pkg::op_t                    pend_op_r;
  logic signed [MUL_W-1:0]         prod_r;
  coord_t                          base_r;
  logic                            out_valid_r;
  coord_t                          pos_x_r;
  coord_t                          pos_y_r;
  logic [cbs_pkg::STEP_W-1:0]      step_index_r;
  logic                            done_res_r;

  logic [cbs_pkg::STEP_W-1:0]      used_nxt;
  logic [cbs_pkg::STEP_W:0]        sum_nxt;
  logic                            wrap_nxt;
  logic [cbs_pkg::STEP_W-1:0]      step_nxt;
  logic [cbs_pkg::STEP_W+cbs_pkg::T_W-1:0] t_full;
  cbs_pkg::op_t                    op;
  coord_t                          opa;
  coord_t                          opb;
  logic signed [cbs_pkg::COORD_W+1:0] diff;
  logic signed [MUL_W-1:0]         mult;
  coord_t                          res;

  always_comb begin
    used_nxt = in_ch.restart ? '0 : step_r;
    sum_nxt  = {1'b0, used_nxt} + 1'b1;
    wrap_nxt = (sum_nxt >= STEPS_V);
    step_nxt = wrap_nxt ? '0 : sum_nxt[cbs_pkg::STEP_W-1:0];
    t_full   = used_nxt * STEP_INC_V;
  end

  always_comb begin
    op   = cbs_pkg::prog_op(s_r);
    opa  = q_r[axis_r][0];
    opb  = q_r[axis_r][1];
    diff = $signed({2'b00, opb}) - $signed({2'b00, opa});
    mult = diff * $signed({1'b0, t_r});
    res  = base_r + coord_t'(prod_r[cbs_pkg::T_W +: cbs_pkg::COORD_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      regs_r      <= '{default: '0};
      step_r      <= '0;
      s_r         <= '0;
      axis_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index < cbs_pkg::CFG_IDX_W'(cbs_pkg::NUM_REGS))) begin
        regs_r[cfg_index[cbs_pkg::REG_IDX_W-1:0]] <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      if (pend_v_r) begin
        case (pend_op_r)
          cbs_pkg::OP_BL3: begin
            q_r[pend_axis_r][0] <= q_r[pend_axis_r][1];
            q_r[pend_axis_r][1] <= q_r[pend_axis_r][2];
            q_r[pend_axis_r][2] <= q_r[pend_axis_r][3];
            q_r[pend_axis_r][3] <= res;
          end
          cbs_pkg::OP_BL2: begin
            q_r[pend_axis_r][0] <= q_r[pend_axis_r][1];
            q_r[pend_axis_r][1] <= q_r[pend_axis_r][2];
            q_r[pend_axis_r][2] <= res;
          end
          cbs_pkg::OP_BL0: begin
            q_r[pend_axis_r][0] <= res;
          end
          default: begin
          end
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            used_r  <= used_nxt;
            done_r  <= wrap_nxt;
            step_r  <= step_nxt;
            t_r     <= t_full[cbs_pkg::T_W-1:0];
            s_r     <= '0;
            axis_r  <= 1'b0;
            q_r[0][0] <= {regs_r[cbs_pkg::REG_START_X], 4'b0000};
            q_r[0][1] <= {regs_r[cbs_pkg::REG_FIRST_CTRL_X], 4'b0000};
            q_r[0][2] <= {regs_r[cbs_pkg::REG_SECOND_CTRL_X], 4'b0000};
            q_r[0][3] <= {regs_r[cbs_pkg::REG_END_X], 4'b0000};
            q_r[1][0] <= {regs_r[cbs_pkg::REG_START_Y], 4'b0000};
            q_r[1][1] <= {regs_r[cbs_pkg::REG_FIRST_CTRL_Y], 4'b0000};
            q_r[1][2] <= {regs_r[cbs_pkg::REG_SECOND_CTRL_Y], 4'b0000};
            q_r[1][3] <= {regs_r[cbs_pkg::REG_END_Y], 4'b0000};
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (op == cbs_pkg::OP_DROP) begin
            pend_v_r       <= 1'b0;
            q_r[axis_r][0] <= q_r[axis_r][1];
            q_r[axis_r][1] <= q_r[axis_r][2];
            q_r[axis_r][2] <= q_r[axis_r][3];
          end else begin
            pend_v_r    <= 1'b1;
            pend_axis_r <= axis_r;
            pend_op_r   <= op;
            prod_r      <= mult;
            base_r      <= opa;
          end
          axis_r <= ~axis_r;
          if (axis_r) begin
            s_r <= s_r + 1'b1;
            if (s_r == cbs_pkg::PROG_W'(cbs_pkg::PROG_LEN - 1)) begin
              state_r <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          pend_v_r <= 1'b0;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            pos_x_r      <= q_r[0][0];
            pos_y_r      <= q_r[1][0];
            step_index_r <= used_r;
            done_res_r   <= done_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pos_x      = pos_x_r;
  assign out_ch.pos_y      = pos_y_r;
  assign out_ch.step_index = step_index_r;
  assign out_ch.done_res   = done_res_r;

endmodule

// File: rtl/cbs_checker.sv
// Port-level checks for the Bezier stepper, bound to its top level.
module cbs_checker #(
  parameter int STEPS = cbs_pkg::STEPS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cbs_pkg::COORD_W-1:0]  pos_x,
  input logic [cbs_pkg::COORD_W-1:0]  pos_y,
  input logic [cbs_pkg::STEP_W-1:0]   step_index,
  input logic                         done_res
);

  localparam logic [cbs_pkg::STEP_W:0] STEPS_V = (cbs_pkg::STEP_W + 1)'(STEPS);
  localparam logic [cbs_pkg::STEP_W:0] LAST_V  = (cbs_pkg::STEP_W + 1)'(STEPS - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(step_index) && $stable(done_res))
    else $error("output beat changed while stalled");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, step_index} < STEPS_V))
    else $error("step index out of range");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (done_res == ({1'b0, step_index} == LAST_V)))
    else $error("done flag disagrees with step index");

  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("ready or result too early after tick beat");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind cubic_bezier_stepper cbs_checker #(.STEPS(STEPS)) u_cbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pos_x      (out_ch.pos_x),
  .pos_y      (out_ch.pos_y),
  .step_index (out_ch.step_index),
  .done_res   (out_ch.done_res)
);
